@@ rtl/source_token_scanner_top_defines.svh @@
// Assertion macros for the source token scanner
`ifndef SOURCE_TOKEN_SCANNER_TOP_DEFINES_SVH
`define SOURCE_TOKEN_SCANNER_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define STS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define STS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define STS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define STS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ rtl/sts_pkg.sv @@
// ----------------------------------------------------------------------------
// sts_pkg
// Shared types, codes and constants of the source token scanner.
// ----------------------------------------------------------------------------
package sts_pkg;

    localparam int MAX_LEXEME_DEF = 64;
    localparam int KW_MAX = 8;
    localparam logic [30:0] INT_SAT = 31'h7FFF_FFFF;

    localparam logic [4:0] TK_ERROR = 5'd0;
    localparam logic [4:0] TK_EOF   = 5'd1;
    localparam logic [4:0] TK_IDENT = 5'd2;
    localparam logic [4:0] TK_INT   = 5'd3;
    localparam logic [4:0] TK_FLOAT = 5'd4;
    localparam logic [4:0] TK_STR   = 5'd5;
    localparam logic [4:0] TK_BOOL  = 5'd6;
    localparam logic [4:0] TK_KW_FUNCTION = 5'd7;
    localparam logic [4:0] TK_KW_BEGIN    = 5'd8;
    localparam logic [4:0] TK_KW_END      = 5'd9;
    localparam logic [4:0] TK_KW_GLOBAL   = 5'd10;
    localparam logic [4:0] TK_KW_INTEGER  = 5'd11;
    localparam logic [4:0] TK_KW_FLOAT    = 5'd12;
    localparam logic [4:0] TK_KW_BOOLEAN  = 5'd13;
    localparam logic [4:0] TK_KW_STRING   = 5'd14;
    localparam logic [4:0] TK_KW_IF       = 5'd15;
    localparam logic [4:0] TK_KW_THEN     = 5'd16;
    localparam logic [4:0] TK_KW_ELSE     = 5'd17;
    localparam logic [4:0] TK_KW_FOR      = 5'd18;
    localparam logic [4:0] TK_KW_NOT      = 5'd19;
    localparam logic [4:0] TK_ASSIGN = 5'd20;
    localparam logic [4:0] TK_GE    = 5'd21;
    localparam logic [4:0] TK_LE    = 5'd22;
    localparam logic [4:0] TK_EQ    = 5'd23;
    localparam logic [4:0] TK_NE    = 5'd24;
    localparam logic [4:0] TK_OP    = 5'd25;

    localparam logic [2:0] ERR_NONE  = 3'd0;
    localparam logic [2:0] ERR_EQ    = 3'd1;
    localparam logic [2:0] ERR_COLON = 3'd2;
    localparam logic [2:0] ERR_LONG  = 3'd3;
    localparam logic [2:0] ERR_DOT   = 3'd4;
    localparam logic [2:0] ERR_NUL   = 3'd5;

    typedef enum logic [7:0] {
        M_IDLE    = 8'b0000_0001,
        M_PAIR    = 8'b0000_0010,
        M_STRING  = 8'b0000_0100,
        M_ESCAPE  = 8'b0000_1000,
        M_COMMENT = 8'b0001_0000,
        M_IDENT   = 8'b0010_0000,
        M_NUMBER  = 8'b0100_0000,
        M_FLOAT   = 8'b1000_0000
    } mode_t;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_input;
    } in_word_t;

    typedef struct packed {
        logic [4:0]  token_kind;
        logic [7:0]  op_char;
        logic [30:0] int_value;
        logic        bool_value;
        logic [6:0]  lexeme_length;
        logic [31:0] line_number;
        logic [2:0]  error_code;
        logic        last_of_run;
    } out_word_t;

    // Classified character handed from the front to the back
    typedef struct packed {
        logic [7:0] ch;
        logic       eoi;
        logic       is_digit;
        logic       is_letter;
        logic       is_single_op;
        logic       is_prefix;
    } cls_word_t;

    typedef logic [KW_MAX*8-1:0] kw_buf_t;

    function automatic logic [63:0] kw_str(input string s);
        logic [63:0] r;
        r = '0;
        for (int i = 0; i < 8; i++)
        begin
            if (i < s.len())
            begin
                r[i*8 +: 8] = s[i];
            end
        end
        return r;
    endfunction

    // Keyword match over buffered bytes; returns kind, ident on no match
    function automatic logic [5:0] kw_match(input kw_buf_t buf_w, input logic [3:0] len);
        logic [63:0] b;
        logic [4:0] k;
        logic bv;
        b = '0;
        for (int i = 0; i < 8; i++)
        begin
            if (4'(i) < len)
            begin
                b[i*8 +: 8] = buf_w[i*8 +: 8];
            end
        end
        k = TK_IDENT;
        bv = 1'b0;
        case (len)
            4'd2:
            begin
                if (b == kw_str("if")) k = TK_KW_IF;
            end
            4'd3:
            begin
                if (b == kw_str("end")) k = TK_KW_END;
                else if (b == kw_str("for")) k = TK_KW_FOR;
                else if (b == kw_str("not")) k = TK_KW_NOT;
            end
            4'd4:
            begin
                if (b == kw_str("then")) k = TK_KW_THEN;
                else if (b == kw_str("else")) k = TK_KW_ELSE;
                else if (b == kw_str("true"))
                begin
                    k = TK_BOOL;
                    bv = 1'b1;
                end
            end
            4'd5:
            begin
                if (b == kw_str("begin")) k = TK_KW_BEGIN;
                else if (b == kw_str("float")) k = TK_KW_FLOAT;
                else if (b == kw_str("false")) k = TK_BOOL;
            end
            4'd6:
            begin
                if (b == kw_str("global")) k = TK_KW_GLOBAL;
                else if (b == kw_str("string")) k = TK_KW_STRING;
            end
            4'd7:
            begin
                if (b == kw_str("integer")) k = TK_KW_INTEGER;
                else if (b == kw_str("boolean")) k = TK_KW_BOOLEAN;
            end
            4'd8:
            begin
                if (b == kw_str("function")) k = TK_KW_FUNCTION;
            end
            default:
            begin
                k = TK_IDENT;
            end
        endcase
        return {k, bv};
    endfunction

endpackage

@@ rtl/sts_front.sv @@
// ----------------------------------------------------------------------------
// sts_front
// Input stage: register and classify each incoming character.
// ----------------------------------------------------------------------------
module sts_front (
    input  logic                clk,
    input  logic                rst_n,
    input  sts_pkg::in_word_t   in_word,
    input  logic                in_valid,
    output logic                in_ready,
    output sts_pkg::cls_word_t  cls_word,
    output logic                cls_valid,
    input  logic                cls_ready
);

    sts_pkg::cls_word_t cls_reg;
    sts_pkg::cls_word_t cls_next;
    logic               valid_reg;
    logic [7:0]         c;

    assign c = in_word.char_code;
    assign in_ready = !valid_reg || cls_ready;

    always_comb
    begin
        cls_next.ch = c;
        cls_next.eoi = in_word.end_of_input;
        cls_next.is_digit = (c >= 8'h30) && (c <= 8'h39);
        cls_next.is_letter = ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
        cls_next.is_single_op = (c == 8'h2B) || (c == 8'h2D) || (c == 8'h2A) ||
                                (c == 8'h28) || (c == 8'h29) || (c == 8'h5B) ||
                                (c == 8'h5D) || (c == 8'h2C) || (c == 8'h7C) ||
                                (c == 8'h26) || (c == 8'h3B);
        cls_next.is_prefix = (c == 8'h2F) || (c == 8'h3D) || (c == 8'h3A) ||
                             (c == 8'h3C) || (c == 8'h3E) || (c == 8'h21);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            cls_reg <= cls_next;
        end
    end

    assign cls_word = cls_reg;
    assign cls_valid = valid_reg;

endmodule

@@ rtl/sts_queue.sv @@
// ----------------------------------------------------------------------------
// sts_queue
// Two-entry queue of classified characters between front and back.
// ----------------------------------------------------------------------------
module sts_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  sts_pkg::cls_word_t  wr_word,
    input  logic                wr_valid,
    output logic                wr_ready,
    output sts_pkg::cls_word_t  rd_word,
    output logic                rd_valid,
    input  logic                rd_ready
);

    sts_pkg::cls_word_t mem_reg [2];
    logic               wr_ptr_reg;
    logic               rd_ptr_reg;
    logic [1:0]         count_reg;
    logic               do_wr;
    logic               do_rd;

    assign wr_ready = (count_reg != 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_word  = mem_reg[rd_ptr_reg];
    assign do_wr = wr_valid && wr_ready;
    assign do_rd = rd_valid && rd_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_wr) wr_ptr_reg <= !wr_ptr_reg;
            if (do_rd) rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_reg + {1'b0, do_wr} - {1'b0, do_rd};
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_word;
        end
    end

endmodule

@@ rtl/sts_back.sv @@
// ----------------------------------------------------------------------------
// sts_back
// Scanner state machine: consume classified characters, build tokens.
// ----------------------------------------------------------------------------
`include "source_token_scanner_top_defines.svh"

module sts_back #(
    parameter int MAX_LEXEME = sts_pkg::MAX_LEXEME_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  sts_pkg::cls_word_t  cls_word,
    input  logic                cls_valid,
    output logic                cls_ready,
    output sts_pkg::out_word_t  out_word,
    output logic                out_valid,
    input  logic                out_ready
);

    localparam int CW = $clog2(MAX_LEXEME + 2);
    localparam logic [CW-1:0] MAXL = CW'(MAX_LEXEME);

    sts_pkg::mode_t     mode_reg, mode_next;
    logic [7:0]         prefix_reg, prefix_next;
    sts_pkg::kw_buf_t   kw_reg, kw_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic [30:0]        acc_reg, acc_next;
    logic [31:0]        line_reg, line_next;

    // Two-slot output buffer: slot 0 presented, slot 1 behind it
    sts_pkg::out_word_t slot_reg [2];
    logic [1:0]         fill_reg;

    sts_pkg::out_word_t r0, r1;
    logic               e0, e1;
    logic               take;
    logic [1:0]         after_pop;
    logic [7:0]         c;
    logic [CW-1:0]      held;
    logic [5:0]         kwr;
    logic [35:0]        mul;
    logic [3:0]         kw_len;

    assign c = cls_word.ch;
    assign after_pop = fill_reg - {1'b0, out_ready && (fill_reg != 2'd0)};
    assign cls_ready = (after_pop == 2'd0);
    assign take = cls_valid && cls_ready;
    assign held = (cnt_reg > MAXL) ? MAXL : cnt_reg;
    assign kw_len = (cnt_reg <= CW'(sts_pkg::KW_MAX)) ? 4'(cnt_reg) : 4'd0;
    assign kwr = sts_pkg::kw_match(kw_reg, kw_len);
    assign mul = {5'd0, acc_reg} * 36'd10 + {32'd0, c[3:0]};

    function automatic sts_pkg::out_word_t mk(input logic [4:0] k, input logic [7:0] op,
                                              input logic [30:0] iv, input logic bv,
                                              input logic [6:0] len, input logic [31:0] ln,
                                              input logic [2:0] err);
        sts_pkg::out_word_t w;
        w.token_kind = k;
        w.op_char = op;
        w.int_value = iv;
        w.bool_value = bv;
        w.lexeme_length = len;
        w.line_number = ln;
        w.error_code = err;
        w.last_of_run = 1'b0;
        return w;
    endfunction

    always_comb
    begin
        logic rescan;
        logic [CW-1:0] grown;
        logic [6:0] held7;
        logic [6:0] cnt7;
        logic [4:0] pk;
        rescan = 1'b0;
        grown = '0;
        held7 = 7'(held);
        cnt7 = 7'(cnt_reg);
        pk = sts_pkg::TK_NE;
        mode_next = mode_reg;
        prefix_next = prefix_reg;
        kw_next = kw_reg;
        cnt_next = cnt_reg;
        acc_next = acc_reg;
        line_next = line_reg;
        e0 = 1'b0;
        e1 = 1'b0;
        r0 = mk(sts_pkg::TK_EOF, 8'd0, 31'd0, 1'b0, 7'd0, line_reg, sts_pkg::ERR_NONE);
        r1 = r0;
        if (cls_word.eoi)
        begin
            e0 = 1'b1;
            case (mode_reg)
                sts_pkg::M_PAIR:
                begin
                    e1 = 1'b1;
                    if (prefix_reg == 8'h3D)
                        r0 = mk(sts_pkg::TK_ERROR, 8'd0, 31'd0, 1'b0, 7'd1, line_reg,
                                sts_pkg::ERR_EQ);
                    else if (prefix_reg == 8'h3A)
                        r0 = mk(sts_pkg::TK_ERROR, 8'd0, 31'd0, 1'b0, 7'd1, line_reg,
                                sts_pkg::ERR_COLON);
                    else
                        r0 = mk(sts_pkg::TK_OP, prefix_reg, 31'd0, 1'b0, 7'd1, line_reg,
                                sts_pkg::ERR_NONE);
                end
                sts_pkg::M_STRING, sts_pkg::M_ESCAPE:
                begin
                    e1 = 1'b1;
                    r0 = mk(sts_pkg::TK_ERROR, 8'd0, 31'd0, 1'b0, held7, line_reg,
                            sts_pkg::ERR_LONG);
                end
                sts_pkg::M_IDENT:
                begin
                    e1 = 1'b1;
                    r0 = mk(kwr[5:1], 8'd0, 31'd0, kwr[0], cnt7, line_reg, sts_pkg::ERR_NONE);
                end
                sts_pkg::M_NUMBER:
                begin
                    e1 = 1'b1;
                    r0 = mk(sts_pkg::TK_INT, 8'd0, acc_reg, 1'b0, cnt7, line_reg,
                            sts_pkg::ERR_NONE);
                end
                sts_pkg::M_FLOAT:
                begin
                    e1 = 1'b1;
                    r0 = mk(sts_pkg::TK_FLOAT, 8'd0, 31'd0, 1'b0, cnt7, line_reg,
                            sts_pkg::ERR_NONE);
                end
                default:
                begin
                    e1 = 1'b0;
                end
            endcase
            mode_next = sts_pkg::M_IDLE;
        end
        else
        begin
            case (mode_reg)
                sts_pkg::M_PAIR:
                begin
                    mode_next = sts_pkg::M_IDLE;
                    if (prefix_reg == 8'h2F)
                    begin
                        if (c == 8'h2F)
                            mode_next = sts_pkg::M_COMMENT;
                        else
                        begin
                            e0 = 1'b1;
                            r0 = mk(sts_pkg::TK_OP, 8'h2F, 31'd0, 1'b0, 7'd1, line_reg,
                                    sts_pkg::ERR_NONE);
                            rescan = 1'b1;
                        end
                    end
                    else if (c == 8'h3D)
                    begin
                        if (prefix_reg == 8'h3A) pk = sts_pkg::TK_ASSIGN;
                        else if (prefix_reg == 8'h3E) pk = sts_pkg::TK_GE;
                        else if (prefix_reg == 8'h3C) pk = sts_pkg::TK_LE;
                        else if (prefix_reg == 8'h3D) pk = sts_pkg::TK_EQ;
                        e0 = 1'b1;
                        r0 = mk(pk, 8'd0, 31'd0, 1'b0, 7'd2, line_reg, sts_pkg::ERR_NONE);
                    end
                    else
                    begin
                        e0 = 1'b1;
                        rescan = 1'b1;
                        if (prefix_reg == 8'h3D)
                            r0 = mk(sts_pkg::TK_ERROR, 8'd0, 31'd0, 1'b0, 7'd1, line_reg,
                                    sts_pkg::ERR_EQ);
                        else if (prefix_reg == 8'h3A)
                            r0 = mk(sts_pkg::TK_ERROR, 8'd0, 31'd0, 1'b0, 7'd1, line_reg,
                                    sts_pkg::ERR_COLON);
                        else
                            r0 = mk(sts_pkg::TK_OP, prefix_reg, 31'd0, 1'b0, 7'd1, line_reg,
                                    sts_pkg::ERR_NONE);
                    end
                end
                sts_pkg::M_COMMENT:
                begin
                    if (c == 8'h0A)
                    begin
                        line_next = line_reg + 32'd1;
                        mode_next = sts_pkg::M_IDLE;
                    end
                end
                sts_pkg::M_STRING, sts_pkg::M_ESCAPE:
                begin
                    if (mode_reg == sts_pkg::M_STRING && c == 8'h22)
                    begin
                        e0 = 1'b1;
                        r0 = mk(sts_pkg::TK_STR, 8'd0, 31'd0, 1'b0, cnt7, line_reg,
                                sts_pkg::ERR_NONE);
                        mode_next = sts_pkg::M_IDLE;
                    end
                    else if (mode_reg == sts_pkg::M_STRING && c == 8'h5C)
                        mode_next = sts_pkg::M_ESCAPE;
                    else
                    begin
                        mode_next = sts_pkg::M_STRING;
                        grown = cnt_reg + ((mode_reg == sts_pkg::M_ESCAPE && c == 8'h6E)
                                           ? CW'(2) : CW'(1));
                        cnt_next = grown;
                        if (grown >= MAXL)
                        begin
                            e0 = 1'b1;
                            r0 = mk(sts_pkg::TK_ERROR, 8'd0, 31'd0, 1'b0,
                                    7'((grown > MAXL) ? MAXL : grown), line_reg,
                                    sts_pkg::ERR_LONG);
                            mode_next = sts_pkg::M_IDLE;
                        end
                    end
                end
                sts_pkg::M_IDENT:
                begin
                    if (cls_word.is_digit || cls_word.is_letter)
                    begin
                        if (cnt_reg < CW'(sts_pkg::KW_MAX))
                            kw_next[3'(cnt_reg)*8 +: 8] = c;
                        grown = cnt_reg + CW'(1);
                        cnt_next = grown;
                        if (grown >= MAXL)
                        begin
                            e0 = 1'b1;
                            r0 = mk(sts_pkg::TK_ERROR, 8'd0, 31'd0, 1'b0, 7'(MAXL), line_reg,
                                    sts_pkg::ERR_LONG);
                            mode_next = sts_pkg::M_IDLE;
                        end
                    end
                    else
                    begin
                        e0 = 1'b1;
                        r0 = mk(kwr[5:1], 8'd0, 31'd0, kwr[0], cnt7, line_reg,
                                sts_pkg::ERR_NONE);
                        mode_next = sts_pkg::M_IDLE;
                        rescan = 1'b1;
                    end
                end
                sts_pkg::M_NUMBER, sts_pkg::M_FLOAT:
                begin
                    if (cls_word.is_digit)
                    begin
                        if (mode_reg == sts_pkg::M_NUMBER)
                            acc_next = (mul > {5'd0, sts_pkg::INT_SAT}) ? sts_pkg::INT_SAT
                                                                      : mul[30:0];
                        grown = cnt_reg + CW'(1);
                        cnt_next = grown;
                        if (grown >= MAXL)
                        begin
                            e0 = 1'b1;
                            r0 = mk(sts_pkg::TK_ERROR, 8'd0, 31'd0, 1'b0, 7'(MAXL), line_reg,
                                    sts_pkg::ERR_LONG);
                            mode_next = sts_pkg::M_IDLE;
                        end
                    end
                    else if (c == 8'h2E)
                    begin
                        if (mode_reg == sts_pkg::M_NUMBER)
                        begin
                            cnt_next = cnt_reg + CW'(1);
                            mode_next = sts_pkg::M_FLOAT;
                        end
                        else
                        begin
                            e0 = 1'b1;
                            r0 = mk(sts_pkg::TK_ERROR, 8'd0, 31'd0, 1'b0, held7, line_reg,
                                    sts_pkg::ERR_DOT);
                            mode_next = sts_pkg::M_IDLE;
                        end
                    end
                    else if (c == 8'h00)
                    begin
                        e0 = 1'b1;
                        r0 = mk(sts_pkg::TK_ERROR, 8'd0, 31'd0, 1'b0, held7, line_reg,
                                sts_pkg::ERR_NUL);
                        mode_next = sts_pkg::M_IDLE;
                    end
                    else
                    begin
                        e0 = 1'b1;
                        if (mode_reg == sts_pkg::M_NUMBER)
                            r0 = mk(sts_pkg::TK_INT, 8'd0, acc_reg, 1'b0, cnt7, line_reg,
                                    sts_pkg::ERR_NONE);
                        else
                            r0 = mk(sts_pkg::TK_FLOAT, 8'd0, 31'd0, 1'b0, cnt7, line_reg,
                                    sts_pkg::ERR_NONE);
                        mode_next = sts_pkg::M_IDLE;
                        rescan = 1'b1;
                    end
                end
                default:
                begin
                    rescan = 1'b1;
                end
            endcase
            // Idle scan of the character, either fresh or rescanned
            if (rescan)
            begin
                mode_next = sts_pkg::M_IDLE;
                if (c == 8'h0A)
                    line_next = line_reg + 32'd1;
                else if (cls_word.is_single_op)
                begin
                    if (e0)
                    begin
                        e1 = 1'b1;
                        r1 = mk(sts_pkg::TK_OP, c, 31'd0, 1'b0, 7'd1, line_reg,
                                sts_pkg::ERR_NONE);
                    end
                    else
                    begin
                        e0 = 1'b1;
                        r0 = mk(sts_pkg::TK_OP, c, 31'd0, 1'b0, 7'd1, line_reg,
                                sts_pkg::ERR_NONE);
                    end
                end
                else if (cls_word.is_prefix)
                begin
                    prefix_next = c;
                    mode_next = sts_pkg::M_PAIR;
                end
                else if (c == 8'h22)
                begin
                    cnt_next = '0;
                    mode_next = sts_pkg::M_STRING;
                end
                else if (cls_word.is_digit)
                begin
                    cnt_next = CW'(1);
                    acc_next = {27'd0, c[3:0]};
                    mode_next = sts_pkg::M_NUMBER;
                end
                else if (cls_word.is_letter)
                begin
                    cnt_next = CW'(1);
                    kw_next[7:0] = c;
                    mode_next = sts_pkg::M_IDENT;
                end
            end
        end
        if (e1)
            r1.last_of_run = 1'b1;
        else
            r0.last_of_run = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= sts_pkg::M_IDLE;
            prefix_reg <= 8'd0;
            cnt_reg    <= '0;
            acc_reg    <= '0;
            line_reg   <= 32'd1;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (take)
            begin
                mode_reg   <= mode_next;
                prefix_reg <= prefix_next;
                cnt_reg    <= cnt_next;
                acc_reg    <= acc_next;
                line_reg   <= line_next;
                fill_reg   <= {1'b0, e0} + {1'b0, e1};
            end
            else
            begin
                fill_reg <= after_pop;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            kw_reg <= kw_next;
            slot_reg[0] <= r0;
            slot_reg[1] <= r1;
        end
        else if (out_ready && fill_reg == 2'd2)
        begin
            slot_reg[0] <= slot_reg[1];
        end
    end

    assign out_word = slot_reg[0];
    assign out_valid = (fill_reg != 2'd0);

    `STS_ASSERT_IMPL(a_second_needs_first, clk, rst_n, take && e1, e0,
                     "second token without a first")
    `STS_ASSERT_IMPL(a_take_only_drained, clk, rst_n, take, after_pop == 2'd0,
                     "new word taken while tokens still pending")
    `STS_ASSERT_IMPL(a_fill_range, clk, rst_n, 1'b1, fill_reg != 2'd3,
                     "output buffer overfilled")
    `STS_ASSERT_NEXT(a_line_monotonic, clk, rst_n, 1'b1,
                     line_reg >= $past(line_reg) || $past(line_reg) == 32'hFFFF_FFFF,
                     "line count went backwards")

endmodule

@@ rtl/source_token_scanner_top.sv @@
// Path: input words are registered in the front, queued, then scanned by the back.
// Throughput: one character per cycle while tokens are taken; a character that
// gives two tokens holds the scanner while the second token drains.
// Reset: rst_n asynchronous, active low; scanner idle, line count one, queues empty.
// ----------------------------------------------------------------------------
// source_token_scanner_top
// Character-stream lexical scanner: front classifier, queue, token back end.
// ----------------------------------------------------------------------------
module source_token_scanner_top #(
    parameter int MAX_LEXEME = sts_pkg::MAX_LEXEME_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  sts_pkg::in_word_t   in_data,
    input  logic                in_valid,
    output logic                in_ready,
    output sts_pkg::out_word_t  out_data,
    output logic                out_valid,
    input  logic                out_ready
);

    // Classified word from the front register
    sts_pkg::cls_word_t f_word;
    logic               f_valid;
    logic               f_ready;

    // Queue output towards the back end
    sts_pkg::cls_word_t q_word;
    logic               q_valid;
    logic               q_ready;

    // Register and classify each incoming word
    sts_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_word   (in_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cls_word  (f_word),
        .cls_valid (f_valid),
        .cls_ready (f_ready)
    );

    // Decouple front and back so each may stall on its own
    sts_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_word  (f_word),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .rd_word  (q_word),
        .rd_valid (q_valid),
        .rd_ready (q_ready)
    );

    // Advance the scanner state and hold up to two tokens per word
    sts_back #(
        .MAX_LEXEME (MAX_LEXEME)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cls_word  (q_word),
        .cls_valid (q_valid),
        .cls_ready (q_ready),
        .out_word  (out_data),
        .out_valid (out_valid),
        .out_ready (out_ready)
    );

endmodule

@@ verif/source_token_scanner_top_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// source_token_scanner_top_tb
// Self-checking bench: drives character words into the scanner, predicts the
// tokens from its own copy of the scanner state and checks each output word.
// ----------------------------------------------------------------------------
module source_token_scanner_top_tb;

    localparam int LEX_MAX = 64;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 20;

    typedef enum logic [2:0] {
        SC_IDLE, SC_PAIR, SC_STRING, SC_ESCAPE, SC_COMMENT, SC_IDENT, SC_NUMBER,
        SC_FLOAT
    } scan_state_t;

    // ------------------------------------------------------------------------
    // Token scoreboard: its own scanner model plus a queue of expected words
    // ------------------------------------------------------------------------
    class token_scoreboard;
        scan_state_t state;
        logic [7:0]  prefix;
        logic [7:0]  kw_bytes [8];
        int unsigned count;
        logic [30:0] acc;
        logic [31:0] line;
        sts_pkg::out_word_t pending_tokens [$];
        sts_pkg::out_word_t step_tokens [$];
        int          mismatches;
        int          tokens_seen;
        int          words_in;

        function void clear();
            state = SC_IDLE;
            prefix = '0;
            count = 0;
            acc = '0;
            line = 32'd1;
            mismatches = 0;
            tokens_seen = 0;
            words_in = 0;
            pending_tokens.delete();
        endfunction

        function void push_token(logic [4:0] kind, logic [7:0] op, logic [30:0] ival,
                                 logic bval, int unsigned len, logic [2:0] err);
            sts_pkg::out_word_t w;
            if (step_tokens.size() >= 2)
                return;
            w.token_kind = kind;
            w.op_char = (kind == sts_pkg::TK_OP) ? op : 8'd0;
            w.int_value = ival;
            w.bool_value = bval;
            w.lexeme_length = 7'(len);
            w.line_number = line;
            w.error_code = err;
            w.last_of_run = 1'b0;
            step_tokens.push_back(w);
        endfunction

        function void raise_error(logic [2:0] err);
            push_token(sts_pkg::TK_ERROR, 0, 0, 0, (count > LEX_MAX) ? LEX_MAX : count, err);
            state = SC_IDLE;
        endfunction

        function void grow(int unsigned k);
            count += k;
            if (count >= LEX_MAX)
                raise_error(sts_pkg::ERR_LONG);
        endfunction

        function bit word_is(string s);
            if (s.len() != count)
                return 0;
            for (int i = 0; i < s.len(); i++)
            begin
                if (kw_bytes[i] != s[i])
                    return 0;
            end
            return 1;
        endfunction

        function void emit_word();
            logic [4:0] kind;
            logic bv;
            kind = sts_pkg::TK_IDENT;
            bv = 0;
            if (word_is("function")) kind = sts_pkg::TK_KW_FUNCTION;
            else if (word_is("begin")) kind = sts_pkg::TK_KW_BEGIN;
            else if (word_is("end")) kind = sts_pkg::TK_KW_END;
            else if (word_is("global")) kind = sts_pkg::TK_KW_GLOBAL;
            else if (word_is("integer")) kind = sts_pkg::TK_KW_INTEGER;
            else if (word_is("float")) kind = sts_pkg::TK_KW_FLOAT;
            else if (word_is("boolean")) kind = sts_pkg::TK_KW_BOOLEAN;
            else if (word_is("string")) kind = sts_pkg::TK_KW_STRING;
            else if (word_is("if")) kind = sts_pkg::TK_KW_IF;
            else if (word_is("then")) kind = sts_pkg::TK_KW_THEN;
            else if (word_is("else")) kind = sts_pkg::TK_KW_ELSE;
            else if (word_is("for")) kind = sts_pkg::TK_KW_FOR;
            else if (word_is("not")) kind = sts_pkg::TK_KW_NOT;
            else if (word_is("true"))
            begin
                kind = sts_pkg::TK_BOOL;
                bv = 1;
            end
            else if (word_is("false")) kind = sts_pkg::TK_BOOL;
            push_token(kind, 0, 0, bv, count, sts_pkg::ERR_NONE);
        endfunction

        function void prefix_alone();
            if (prefix == "=") push_token(sts_pkg::TK_ERROR, 0, 0, 0, 1, sts_pkg::ERR_EQ);
            else if (prefix == ":")
                push_token(sts_pkg::TK_ERROR, 0, 0, 0, 1, sts_pkg::ERR_COLON);
            else push_token(sts_pkg::TK_OP, prefix, 0, 0, 1, sts_pkg::ERR_NONE);
        endfunction

        function bit is_digit(logic [7:0] c);
            return c >= "0" && c <= "9";
        endfunction

        function bit is_letter(logic [7:0] c);
            return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
        endfunction

        function void scan_from_idle(logic [7:0] c);
            state = SC_IDLE;
            if (c == 8'h0A)
                line++;
            else if (c inside {"+", "-", "*", "(", ")", "[", "]", ",", "|", "&", ";"})
                push_token(sts_pkg::TK_OP, c, 0, 0, 1, sts_pkg::ERR_NONE);
            else if (c inside {"/", "=", ":", "<", ">", "!"})
            begin
                prefix = c;
                state = SC_PAIR;
            end
            else if (c == 8'h22)
            begin
                count = 0;
                state = SC_STRING;
            end
            else if (is_digit(c))
            begin
                count = 1;
                acc = 31'(c - "0");
                state = SC_NUMBER;
            end
            else if (is_letter(c))
            begin
                count = 1;
                kw_bytes[0] = c;
                state = SC_IDENT;
            end
        endfunction

        // Returns 1 when the character must be scanned again from idle
        function bit scan_char(logic [7:0] c);
            logic [63:0] wide;
            case (state)
                SC_PAIR:
                begin
                    state = SC_IDLE;
                    if (prefix == "/")
                    begin
                        if (c == "/")
                        begin
                            state = SC_COMMENT;
                            return 0;
                        end
                        push_token(sts_pkg::TK_OP, "/", 0, 0, 1, sts_pkg::ERR_NONE);
                        return 1;
                    end
                    if (c == "=")
                    begin
                        push_token(prefix == ":" ? sts_pkg::TK_ASSIGN :
                                   prefix == ">" ? sts_pkg::TK_GE :
                                   prefix == "<" ? sts_pkg::TK_LE :
                                   prefix == "=" ? sts_pkg::TK_EQ : sts_pkg::TK_NE,
                                   0, 0, 0, 2, sts_pkg::ERR_NONE);
                        return 0;
                    end
                    prefix_alone();
                    return 1;
                end
                SC_COMMENT:
                begin
                    if (c == 8'h0A)
                    begin
                        line++;
                        state = SC_IDLE;
                    end
                    return 0;
                end
                SC_STRING:
                begin
                    if (c == 8'h22)
                    begin
                        push_token(sts_pkg::TK_STR, 0, 0, 0, count, sts_pkg::ERR_NONE);
                        state = SC_IDLE;
                    end
                    else if (c == 8'h5C)
                        state = SC_ESCAPE;
                    else
                        grow(1);
                    return 0;
                end
                SC_ESCAPE:
                begin
                    state = SC_STRING;
                    grow(c == "n" ? 2 : 1);
                    return 0;
                end
                SC_IDENT:
                begin
                    if (is_digit(c) || is_letter(c))
                    begin
                        if (count < 8)
                            kw_bytes[count] = c;
                        grow(1);
                        return 0;
                    end
                    emit_word();
                    state = SC_IDLE;
                    return 1;
                end
                SC_NUMBER:
                begin
                    if (is_digit(c))
                    begin
                        wide = 64'(acc) * 10 + 64'(c - "0");
                        acc = (wide > 64'(sts_pkg::INT_SAT)) ? sts_pkg::INT_SAT : wide[30:0];
                        grow(1);
                        return 0;
                    end
                    if (c == ".")
                    begin
                        count++;
                        state = SC_FLOAT;
                        return 0;
                    end
                    if (c == 0)
                    begin
                        raise_error(sts_pkg::ERR_NUL);
                        return 0;
                    end
                    push_token(sts_pkg::TK_INT, 0, acc, 0, count, sts_pkg::ERR_NONE);
                    state = SC_IDLE;
                    return 1;
                end
                SC_FLOAT:
                begin
                    if (is_digit(c))
                    begin
                        grow(1);
                        return 0;
                    end
                    if (c == "." || c == 0)
                    begin
                        raise_error(c == 0 ? sts_pkg::ERR_NUL : sts_pkg::ERR_DOT);
                        return 0;
                    end
                    push_token(sts_pkg::TK_FLOAT, 0, 0, 0, count, sts_pkg::ERR_NONE);
                    state = SC_IDLE;
                    return 1;
                end
                default:
                begin
                    scan_from_idle(c);
                    return 0;
                end
            endcase
        endfunction

        function void flush_at_eof();
            case (state)
                SC_PAIR:
                begin
                    if (prefix == "/")
                        push_token(sts_pkg::TK_OP, "/", 0, 0, 1, sts_pkg::ERR_NONE);
                    else prefix_alone();
                end
                SC_STRING, SC_ESCAPE: raise_error(sts_pkg::ERR_LONG);
                SC_IDENT: emit_word();
                SC_NUMBER: push_token(sts_pkg::TK_INT, 0, acc, 0, count, sts_pkg::ERR_NONE);
                SC_FLOAT: push_token(sts_pkg::TK_FLOAT, 0, 0, 0, count, sts_pkg::ERR_NONE);
                default: ;
            endcase
            state = SC_IDLE;
            push_token(sts_pkg::TK_EOF, 0, 0, 0, 0, sts_pkg::ERR_NONE);
        endfunction

        // Note one accepted input word and queue the tokens it causes
        function void note_input(sts_pkg::in_word_t w);
            step_tokens.delete();
            words_in++;
            if (w.end_of_input)
                flush_at_eof();
            else if (scan_char(w.char_code))
                scan_from_idle(w.char_code);
            if (step_tokens.size() > 0)
                step_tokens[step_tokens.size() - 1].last_of_run = 1'b1;
            foreach (step_tokens[i])
                pending_tokens.push_back(step_tokens[i]);
        endfunction

        // Check one accepted output word against the oldest expected token
        function void check_token(sts_pkg::out_word_t got);
            sts_pkg::out_word_t exp;
            tokens_seen++;
            if (pending_tokens.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected token %p", got);
                return;
            end
            exp = pending_tokens.pop_front();
            if (got.token_kind !== exp.token_kind || got.op_char !== exp.op_char ||
                got.int_value !== exp.int_value || got.bool_value !== exp.bool_value ||
                got.lexeme_length !== exp.lexeme_length ||
                got.line_number !== exp.line_number ||
                got.error_code !== exp.error_code || got.last_of_run !== exp.last_of_run)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: token mismatch\n  expected %p\n  actual   %p", exp, got);
            end
        endfunction
    endclass

    logic      clk;
    logic      rst_n;
    sts_pkg::in_word_t  in_data;
    logic      in_valid;
    logic      in_ready;
    sts_pkg::out_word_t out_data;
    logic      out_valid;
    logic      out_ready;

    token_scoreboard tokens;
    bit          rx_calm;      // no random stalls on the receiver
    bit          rx_hold_req;  // ask the receiver for a long hold-off
    bit          tx_calm;
    int          idle_cycles;

    source_token_scanner_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_data  (out_data),
        .out_valid (out_valid),
        .out_ready (out_ready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Sample both handshakes at the edge; the model sees inputs before outputs
    // of the same edge, which is harmless since a word is registered before its tokens leave.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                tokens.note_input(in_data);
            if (out_valid && out_ready)
                tokens.check_token(out_data);
            if ((in_valid && in_ready) || (out_valid && out_ready) ||
                (!in_valid && tokens.pending_tokens.size() == 0))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // Watchdog: stop the run if nothing moves for too long
    always @(posedge clk)
    begin
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("ERROR: watchdog expired, %0d tokens outstanding",
                     tokens.pending_tokens.size());
            $display("source_token_scanner_top_tb NOT OK");
            $finish;
        end
    end

    // Receiver: random stalls of about 17 in 100, long hold-off on request
    initial
    begin
        int hold;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (rx_hold_req)
            begin
                out_ready <= 1'b0;
                for (hold = 0; hold < 200; hold++)
                    @(posedge clk);
                rx_hold_req = 0;
            end
            out_ready <= rx_calm ? 1'b1 : ($urandom_range(99) >= 17);
        end
    end

    // Offer one word and hold it until accepted, with a random gap before it;
    // valid stays up afterwards until the next word, a gap or a drain drops it
    task automatic send_word(input logic [7:0] c, input logic eoi);
        sts_pkg::in_word_t w;
        while (!tx_calm && $urandom_range(99) < 17)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        w.char_code = c;
        w.end_of_input = eoi;
        in_data <= w;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_word(s[i], 1'b0);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (tokens.pending_tokens.size() != 0)
            @(posedge clk);
    endtask

    // Random fragment: mostly well-formed tokens with random content
    task automatic send_fragment();
        int n;
        case ($urandom_range(11))
            0: send_text("function begin end global integer float boolean string ");
            1:
            begin
                n = $urandom_range(1, 12);
                for (int i = 0; i < n; i++)
                    send_word(8'("0" + $urandom_range(9)), 1'b0);
                if ($urandom_range(2) == 0)
                begin
                    send_word(".", 1'b0);
                    send_word(8'("0" + $urandom_range(9)), 1'b0);
                    if ($urandom_range(4) == 0) send_word(".", 1'b0);
                end
                if ($urandom_range(5) == 0) send_word(8'h00, 1'b0);
                else send_word(" ", 1'b0);
            end
            2:
            begin
                n = $urandom_range(1, 10);
                for (int i = 0; i < n; i++)
                    send_word($urandom_range(1) ? 8'("a" + $urandom_range(25))
                                                 : 8'("A" + $urandom_range(25)), 1'b0);
                send_word(8'(";"), 1'b0);
            end
            3:
            begin
                send_word(8'h22, 1'b0);
                n = $urandom_range(0, 8);
                for (int i = 0; i < n; i++)
                begin
                    if ($urandom_range(4) == 0)
                    begin
                        send_word(8'h5C, 1'b0);
                        send_word($urandom_range(1) ? "n" : 8'($urandom_range(255)), 1'b0);
                    end
                    else
                        send_word(8'($urandom_range(32, 126)) == 8'h22 ? "q"
                                  : 8'($urandom_range(32, 126)), 1'b0);
                end
                send_word(8'h22, 1'b0);
            end
            4: send_text(":= >= <= == != = : < > ! / ");
            5: send_text("// note\x0a");
            6: send_text("if then else for not true false\x0a");
            7: send_text("+-*()[],|&;");
            8: send_word(8'($urandom_range(255)), 1'b0);
            9: send_word(8'h0A, 1'b0);
            10: send_word(8'($urandom_range(255)), 1'b1);
            default:
            begin
                n = $urandom_range(1, 6);
                for (int i = 0; i < n; i++)
                    send_word(8'($urandom_range(255)), 1'b0);
            end
        endcase
    endtask

    initial
    begin
        int n;
        tokens = new();
        tokens.clear();
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        rx_calm = 0;
        rx_hold_req = 0;
        tx_calm = 0;
        idle_cycles = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: operators, prefixes, keywords, saturation, errors, eof
        send_text("a:=12;x>=y!=z==w<=v=q:b//c\x0a");
        send_text("2147483648 9999999999 0.5.1 3.2");
        send_word(8'h00, 1'b0);
        send_text("\"ab\\n\\\"c\" true false then.");
        send_word(8'hFF, 1'b0);
        send_word(8'h0D, 1'b0);
        send_text("\"open");
        send_word(8'h00, 1'b1);
        send_text("name<");
        send_word(8'hA5, 1'b1);
        send_word(8'h5A, 1'b1);
        // Over-length identifier, number and string
        for (int i = 0; i < 66; i++)
            send_word("k", 1'b0);
        for (int i = 0; i < 66; i++)
            send_word("7", 1'b0);
        send_word(8'h22, 1'b0);
        for (int i = 0; i < 33; i++)
        begin
            send_word(8'h5C, 1'b0);
            send_word("n", 1'b0);
        end
        send_word(8'h22, 1'b1);

        // Sender pauses until every expected token has come
        wait_drained();

        // Back-pressure: receiver holds off while the sender keeps offering
        rx_hold_req = 1;
        tx_calm = 1;
        send_text("+-*();,[]|&+-*();,[]|&+-*();,[]|&+-*();,[]|&");
        tx_calm = 0;

        // Random: a calm stretch early on, then random stalls on both sides
        n = 0;
        while (tokens.words_in < 440)
        begin
            rx_calm = (n >= 2 && n < 8);
            tx_calm = rx_calm;
            send_fragment();
            n++;
        end
        send_word(8'h00, 1'b1);
        rx_calm = 0;
        tx_calm = 0;

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Scanned %0d input words into %0d tokens, with stalls, a long hold-off",
                 tokens.words_in, tokens.tokens_seen);
        $display("and directed operator, keyword, number, string and error cases.");
        if (tokens.mismatches == 0 && tokens.pending_tokens.size() == 0)
            $display("source_token_scanner_top_tb OK");
        else
            $display("source_token_scanner_top_tb NOT OK");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl
rtl/sts_pkg.sv
rtl/sts_front.sv
rtl/sts_queue.sv
rtl/sts_back.sv
rtl/source_token_scanner_top.sv
verif/source_token_scanner_top_tb.sv
